/* src/totalistic_cellular_automaton_pass_defines.svh */
// Assertion macros shared by the cellular automaton pass RTL.
`ifndef TOTALISTIC_CELLULAR_AUTOMATON_PASS_DEFINES_SVH
`define TOTALISTIC_CELLULAR_AUTOMATON_PASS_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Condition must never hold while out of reset.
`define TCAP_ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define TCAP_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define TCAP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define TCAP_ASSERT_NEVER(label, clk, rst, expr, msg)
`define TCAP_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define TCAP_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

/* src/tcap_pkg.sv */
// Types and constants of the cellular automaton pass.
package tcap_pkg;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 56;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_GRID_WIDTH     = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_GRID_HEIGHT    = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_NINE_CELL_MODE = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_RULE_COUNT     = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_RULE_TABLE     = 3'd4;

  localparam int CELL_BITS    = 2;
  localparam int SIZE_BITS    = 9;
  localparam int ROW_BITS     = 8;
  localparam int COUNT_BITS   = 16;
  localparam int RULE_BITS    = 5;
  localparam int MIN_SIZE     = 3;
  localparam int HEIGHT_LIMIT = 256;
  localparam int RULE_LIMIT   = 28;
  localparam int CROSS_CELLS  = 5;
  localparam int MOORE_CELLS  = 9;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [CELL_BITS-1:0] cell_value;
    logic                 frame_end;
  } tcap_in_t;

  typedef struct packed {
    logic [CELL_BITS-1:0]  new_value;
    logic [ROW_BITS-1:0]   center_row;
    logic [ROW_BITS-1:0]   center_col;
    logic                  changed;
    logic [COUNT_BITS-1:0] change_total;
    logic                  crossed_over;
    logic                  pass_end;
  } tcap_out_t;

  // Register values as the datapath uses them (height and rule count clamped).
  typedef struct packed {
    logic [SIZE_BITS-1:0]     grid_height;
    logic                     nine_cell_mode;
    logic [RULE_BITS-1:0]     rule_count;
    logic [CFG_DATA_BITS-1:0] rule_table;
  } tcap_cfg_t;

endpackage

/* src/tcap_cfg_regs.sv */
// Configuration registers with range clamping.
module tcap_cfg_regs #(
  parameter int MAX_WIDTH = 256,
  parameter int WW = 9
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [tcap_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [tcap_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output tcap_pkg::tcap_cfg_t                cfg,
  output logic [WW-1:0]                      width_eff
);
  import tcap_pkg::*;

  logic [SIZE_BITS-1:0]     grid_width;
  logic [SIZE_BITS-1:0]     grid_height;
  logic                     nine_cell_mode;
  logic [RULE_BITS-1:0]     rule_count;
  logic [CFG_DATA_BITS-1:0] rule_table;
  logic [WW-1:0]            width_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width     <= SIZE_BITS'(256);
      grid_height    <= SIZE_BITS'(HEIGHT_LIMIT);
      nine_cell_mode <= 1'b0;
      rule_count     <= RULE_BITS'(RULE_LIMIT);
      rule_table     <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_GRID_WIDTH:     grid_width     <= cfg_data[SIZE_BITS-1:0];
        CFG_GRID_HEIGHT:    grid_height    <= cfg_data[SIZE_BITS-1:0];
        CFG_NINE_CELL_MODE: nine_cell_mode <= cfg_data[0];
        CFG_RULE_COUNT:     rule_count     <= cfg_data[RULE_BITS-1:0];
        CFG_RULE_TABLE:     rule_table     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign width_raw = WW'(grid_width);

  always_comb begin
    if (width_raw < WW'(MIN_SIZE)) begin
      width_eff = WW'(MIN_SIZE);
    end else if (width_raw > WW'(MAX_WIDTH)) begin
      width_eff = WW'(MAX_WIDTH);
    end else begin
      width_eff = width_raw;
    end

    if (grid_height < SIZE_BITS'(MIN_SIZE)) begin
      cfg.grid_height = SIZE_BITS'(MIN_SIZE);
    end else if (grid_height > SIZE_BITS'(HEIGHT_LIMIT)) begin
      cfg.grid_height = SIZE_BITS'(HEIGHT_LIMIT);
    end else begin
      cfg.grid_height = grid_height;
    end

    cfg.rule_count = (rule_count > RULE_BITS'(RULE_LIMIT)) ? RULE_BITS'(RULE_LIMIT)
                                                            : rule_count;
    cfg.nine_cell_mode = nine_cell_mode;
    cfg.rule_table     = rule_table;
  end

endmodule

/* src/tcap_line_buffer.sv */
// Two line stores with registered read, write bypass and clearing pass.
module tcap_line_buffer #(
  parameter int MAX_WIDTH = 256,
  parameter int CELL_BITS = 2,
  parameter int CW = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rd_en,
  input  logic [CW-1:0]        rd_addr,
  input  logic                 wr_en,
  input  logic [CW-1:0]        wr_addr,
  input  logic [CELL_BITS-1:0] wr_upper,
  input  logic [CELL_BITS-1:0] wr_middle,
  output logic [CELL_BITS-1:0] rd_upper,
  output logic [CELL_BITS-1:0] rd_middle,
  output logic                 clearing
);

  logic [CELL_BITS-1:0] upper_mem  [MAX_WIDTH];
  logic [CELL_BITS-1:0] middle_mem [MAX_WIDTH];
  logic [CW-1:0]        clr_addr;
  logic [CW-1:0]        mem_addr;
  logic [CELL_BITS-1:0] mem_upper;
  logic [CELL_BITS-1:0] mem_middle;
  logic                 mem_we;
  logic                 bypass;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + CW'(1);
      if (clr_addr == CW'(MAX_WIDTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_comb begin
    mem_we     = clearing || wr_en;
    mem_addr   = clearing ? clr_addr : wr_addr;
    mem_upper  = clearing ? '0 : wr_upper;
    mem_middle = clearing ? '0 : wr_middle;
    bypass     = wr_en && (wr_addr == rd_addr);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      upper_mem[mem_addr]  <= mem_upper;
      middle_mem[mem_addr] <= mem_middle;
    end
  end

  // Forward the data written in the same cycle to the same column.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_upper  <= bypass ? wr_upper  : upper_mem[rd_addr];
      rd_middle <= bypass ? wr_middle : middle_mem[rd_addr];
    end
  end

endmodule

/* src/tcap_cell_update.sv */
// Neighbourhood sum and rule table lookup for one window.
module tcap_cell_update (
  input  tcap_pkg::tcap_cfg_t            cfg,
  input  logic [tcap_pkg::CELL_BITS-1:0] win_a [3],
  input  logic [tcap_pkg::CELL_BITS-1:0] win_b [3],
  input  logic [tcap_pkg::CELL_BITS-1:0] top,
  input  logic [tcap_pkg::CELL_BITS-1:0] mid,
  input  logic [tcap_pkg::CELL_BITS-1:0] newest,
  output logic [tcap_pkg::CELL_BITS-1:0] new_value,
  output logic                           changed
);
  import tcap_pkg::*;

  localparam int SW = $clog2(MOORE_CELLS * ((1 << CELL_BITS) - 1) + 1);
  localparam int RW = (SW > RULE_BITS) ? SW : RULE_BITS;
  localparam int SHW = $clog2(MOORE_CELLS * ((1 << CELL_BITS) - 1) * CELL_BITS + 1);

  logic [SW-1:0]  cross_sum;
  logic [SW-1:0]  sum;
  logic [SHW-1:0] shift;
  logic [63:0]    table_ext;
  logic [CELL_BITS-1:0] center;
  logic [CELL_BITS-1:0] entry;

  always_comb begin
    center    = win_b[1];
    cross_sum = SW'(win_b[0]) + SW'(win_a[1]) + SW'(win_b[1]) + SW'(mid) + SW'(win_b[2]);
    sum       = cfg.nine_cell_mode
                ? cross_sum + SW'(win_a[0]) + SW'(win_a[2]) + SW'(top) + SW'(newest)
                : cross_sum;
    shift     = SHW'(sum) * SHW'(CELL_BITS);
    table_ext = {8'b0, cfg.rule_table};
    // Entries beyond the table read as zero.
    entry     = CELL_BITS'(table_ext >> shift);

    if (RW'(sum) < RW'(cfg.rule_count)) begin
      new_value = entry;
      changed   = (entry != center);
    end else begin
      new_value = center;
      changed   = 1'b0;
    end
  end

endmodule

/* src/totalistic_cellular_automaton_pass.sv */
// Top level of the streamed totalistic cellular automaton pass.
//
// Cells of a grid enter in raster order on the in channel (in_valid, in_stall,
// in_data); the last cell of a grid carries frame_end. Each cell that closes a
// 3x3 window around an interior cell gives one item on the out channel with
// the new value of that centre cell, its position, the change count and the
// sticky crossed flag; other cells give no item.
// One cell is accepted per cycle while in_stall is low. An item reaches the output
// register after its cell is accepted: the accepting edge reads the line stores into
// the stage, and the edge at which the stage advances registers the sum, table lookup and result.
// After reset every column of the line stores is cleared, one column per cycle,
// with in_stall held high; configuration writes are taken.
// When the receiver stalls, the output item holds and the cell in the stage
// before it waits; in_stall rises only when that stage cannot drain or the line stores are clearing.
// Configuration is a plain write port (cfg_wr_en, cfg_index, cfg_data); the user
// must use it only while the block is idle, as the block itself does not enforce this.
`include "totalistic_cellular_automaton_pass_defines.svh"

module totalistic_cellular_automaton_pass #(
  parameter int MAX_WIDTH = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  tcap_pkg::tcap_in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output tcap_pkg::tcap_out_t                 out_data,
  input  logic                                cfg_wr_en,
  input  logic [tcap_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [tcap_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import tcap_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = (CW + 1 > SIZE_BITS) ? CW + 1 : SIZE_BITS;

  tcap_cfg_t cfg;
  logic [WW-1:0] width_eff;

  logic                 accept;
  logic                 clearing;
  logic [ROW_BITS-1:0]  row_pos;
  logic [CW-1:0]        col_pos;
  logic                 col_last;
  logic                 row_last;

  logic                 s1_valid;
  logic                 s1_valid_next;
  logic                 s1_adv;
  logic [CELL_BITS-1:0] s1_cell;
  logic                 s1_fend;
  logic [ROW_BITS-1:0]  s1_row;
  logic [CW-1:0]        s1_col;
  logic [CELL_BITS-1:0] rd_upper;
  logic [CELL_BITS-1:0] rd_middle;

  logic [CELL_BITS-1:0] win_a [3];
  logic [CELL_BITS-1:0] win_b [3];

  logic [CELL_BITS-1:0]   upd_value;
  logic                   upd_changed;
  logic                   has_result;
  logic [ROW_BITS-1:0]    center_row;
  logic [CW-1:0]          center_col;
  logic                   on_ring;
  logic [COUNT_BITS-1:0]  change_counter;
  logic [COUNT_BITS-1:0]  change_counter_next;
  logic                   crossed_flag;
  logic                   crossed_flag_next;
  logic                   s1_pass_end;

  tcap_cfg_regs #(
    .MAX_WIDTH(MAX_WIDTH),
    .WW(WW)
  ) u_cfg (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .cfg(cfg),
    .width_eff(width_eff)
  );

  tcap_line_buffer #(
    .MAX_WIDTH(MAX_WIDTH),
    .CELL_BITS(CELL_BITS),
    .CW(CW)
  ) u_lines (
    .clk(clk),
    .rst(rst),
    .rd_en(accept),
    .rd_addr(col_pos),
    .wr_en(s1_adv),
    .wr_addr(s1_col),
    .wr_upper(rd_middle),
    .wr_middle(s1_cell),
    .rd_upper(rd_upper),
    .rd_middle(rd_middle),
    .clearing(clearing)
  );

  tcap_cell_update u_update (
    .cfg(cfg),
    .win_a(win_a),
    .win_b(win_b),
    .top(rd_upper),
    .mid(rd_middle),
    .newest(s1_cell),
    .new_value(upd_value),
    .changed(upd_changed)
  );

  // Handshake
  assign s1_adv   = s1_valid && (!out_valid || !out_stall);
  assign in_stall = clearing || (s1_valid && !s1_adv);
  assign accept   = in_valid && !in_stall;
  assign s1_valid_next = accept || (s1_valid && !s1_adv);

  // Raster position of the arriving cell
  assign col_last = (WW'(col_pos) + WW'(1)) >= width_eff;
  assign row_last = (SIZE_BITS'(row_pos) + SIZE_BITS'(1)) >= cfg.grid_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_pos <= '0;
      col_pos <= '0;
    end else if (accept) begin
      if (in_data.frame_end) begin
        row_pos <= '0;
        col_pos <= '0;
      end else if (col_last) begin
        col_pos <= '0;
        row_pos <= row_last ? '0 : row_pos + ROW_BITS'(1);
      end else begin
        col_pos <= col_pos + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s1_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cell <= in_data.cell_value;
      s1_fend <= in_data.frame_end;
      s1_row  <= row_pos;
      s1_col  <= col_pos;
    end
  end

  // Window columns: b is one column left of the cell in the stage, a two columns left
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        win_a[i] <= '0;
        win_b[i] <= '0;
      end
    end else if (s1_adv) begin
      for (int i = 0; i < 3; i++) begin
        win_a[i] <= win_b[i];
      end
      win_b[0] <= rd_upper;
      win_b[1] <= rd_middle;
      win_b[2] <= s1_cell;
    end
  end

  // Result of the cell in the stage
  always_comb begin
    has_result  = (s1_row >= ROW_BITS'(2)) && (s1_col >= CW'(2));
    center_row  = s1_row - ROW_BITS'(1);
    center_col  = s1_col - CW'(1);
    on_ring     = (center_row == ROW_BITS'(1)) || (center_col == CW'(1))
                  || ((SIZE_BITS'(center_row) + SIZE_BITS'(2)) == cfg.grid_height)
                  || ((WW'(center_col) + WW'(2)) == width_eff);
    s1_pass_end = ((SIZE_BITS'(s1_row) + SIZE_BITS'(1)) >= cfg.grid_height)
                  && ((WW'(s1_col) + WW'(1)) >= width_eff);

    change_counter_next = change_counter;
    if (has_result && upd_changed && (change_counter != COUNT_MAX)) begin
      change_counter_next = change_counter + COUNT_BITS'(1);
    end
    crossed_flag_next = crossed_flag
                        || (has_result && (upd_value != '0) && on_ring);
  end

  // Clear the pass statistics after the frame's last cell
  always_ff @(posedge clk) begin
    if (rst) begin
      change_counter <= '0;
      crossed_flag   <= 1'b0;
    end else if (s1_adv) begin
      if (s1_fend) begin
        change_counter <= '0;
        crossed_flag   <= 1'b0;
      end else begin
        change_counter <= change_counter_next;
        crossed_flag   <= crossed_flag_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= has_result;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && has_result) begin
      out_data.new_value    <= upd_value;
      out_data.center_row   <= center_row;
      out_data.center_col   <= ROW_BITS'(center_col);
      out_data.changed      <= upd_changed;
      out_data.change_total <= change_counter_next;
      out_data.crossed_over <= crossed_flag_next;
      out_data.pass_end     <= s1_pass_end;
    end
  end

  `TCAP_ASSERT_NEXT(a_stage_holds, clk, rst, s1_valid && !s1_adv, s1_valid && $stable(s1_col), "stalled stage lost its cell")
  `TCAP_ASSERT_IMPLY(a_change_counted, clk, rst, out_valid && out_data.changed, out_data.change_total != '0, "change reported with zero total")
  `TCAP_ASSERT_NEXT(a_counter_monotonic, clk, rst, s1_adv && !s1_fend, change_counter >= $past(change_counter), "change counter decreased within a pass")
  `TCAP_ASSERT_NEVER(a_no_result_clearing, clk, rst, clearing && s1_valid, "cell in stage during line store clearing")

endmodule
